@@ rtl/bpc_pkg.sv @@
`default_nettype none

package bpc_pkg;

  localparam int NSTG = 28;

  localparam int IN_W  = 48;
  localparam int OUT_W = 40;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int CAL_HIGH_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_HIGH = 2'd2;

  localparam int TEMP_MIN  = -4000;
  localparam int TEMP_MAX  = 8500;
  localparam int PRESS_MAX = 12500000;
  localparam int P_OFFSET  = 16384;

  localparam logic signed [7:0] SCALE_CENTI = 8'sd100;

  localparam int RND_W = 96;

  // round to nearest, ties away from zero, after an arithmetic shift right
  function automatic logic signed [RND_W-1:0] bpc_rnd(input logic signed [RND_W-1:0] x,
                                                      input int unsigned sh);
    logic signed [RND_W-1:0] half;
    logic signed [RND_W-1:0] neg;
    half = RND_W'(96'sd1 <<< (sh - 1));
    neg  = $signed({{(RND_W-1){1'b0}}, x[RND_W-1]});
    return (x + half - neg) >>> sh;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bpc_mul.sv @@
`default_nettype none

module bpc_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  wire logic                    clk_i,
  input  wire logic [1:0]              en_i,
  input  wire logic signed [AW-1:0]    a_i,
  input  wire logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0]      p_o
);

  localparam int PW = AW + BW;
  localparam int LA = AW / 2;
  localparam int LB = BW / 2;

  logic        [LA+LB-1:0]         ll_d, ll_q;
  logic signed [LA+BW-LB:0]        lh_d, lh_q;
  logic signed [AW-LA+LB:0]        hl_d, hl_q;
  logic signed [AW-LA+BW-LB-1:0]   hh_d, hh_q;
  logic signed [PW-1:0]            p_d, p_q;

  assign ll_d = a_i[LA-1:0] * b_i[LB-1:0];
  assign lh_d = $signed({1'b0, a_i[LA-1:0]}) * $signed(b_i[BW-1:LB]);
  assign hl_d = $signed(a_i[AW-1:LA]) * $signed({1'b0, b_i[LB-1:0]});
  assign hh_d = $signed(a_i[AW-1:LA]) * $signed(b_i[BW-1:LB]);

  assign p_d = $signed(PW'(ll_q))
             + (PW'(lh_q) <<< LB)
             + (PW'(hl_q) <<< LA)
             + (PW'(hh_q) <<< (LA + LB));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
    end
    if (en_i[1]) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ rtl/bpc_delay.sv @@
`default_nettype none

module bpc_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  wire logic          clk_i,
  input  wire logic [N-1:0]  en_i,
  input  wire logic [W-1:0]  d_i,
  output logic [W-1:0]       q_o
);

  logic [W-1:0] dly_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dly_q[0] <= d_i;
    end
    for (int i = 1; i < N; i++) begin
      if (en_i[i]) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  assign q_o = dly_q[N-1];

endmodule

`default_nettype wire

@@ rtl/baro_pressure_temp_compensation_unit.sv @@
// Barometric pressure and temperature compensation.
// Input stream (s_axis): one request per raw sample pair, raw pressure and
// raw temperature, both 24-bit unsigned. Output stream (m_axis): compensated
// temperature in 0.01 C (clamped to -4000..8500), pressure in 0.01 Pa
// (clamped to 0..12500000) and a flag set when either value was clamped.
// Calibration: 21 bytes in three registers, written through cfg_we_i /
// cfg_idx_i / cfg_data_i while no request is in flight; index 3 is ignored.
// Pipeline: 28 register stages. Throughput: one request per cycle while the
// receiver is not stalling; every stage is a register stage with its own valid
// bit, the wide products are split into partial products over two stages.
// Reset clears all valid bits and the calibration registers.
// When the receiver stalls, a stage holds only while it is full and the next
// one cannot take its data; empty stages keep filling, so the input side
// keeps accepting until the pipeline is full.
`default_nettype none

module baro_pressure_temp_compensation_unit
  import bpc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_W-1:0]       s_axis_tdata,  // raw_pressure, raw_temperature
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_W-1:0]           m_axis_tdata  // temperature_centideg,
                                                   // pressure_centipascal, saturated
);

  logic [CFG_DATA_W-1:0] cal_low_q, cal_mid_q;
  logic [CAL_HIGH_W-1:0] cal_high_q;
  logic [167:0]          cal;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_low_q  <= '0;
      cal_mid_q  <= '0;
      cal_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CALIB_LOW:  cal_low_q  <= cfg_data_i;
        CFG_CALIB_MID:  cal_mid_q  <= cfg_data_i;
        CFG_CALIB_HIGH: cal_high_q <= cfg_data_i[CAL_HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cal = {cal_high_q, cal_mid_q, cal_low_q};

  logic        [15:0] t1_c;
  logic signed [16:0] t2_s, p6_s, p1m, p2m;
  logic signed [7:0]  t3_s, p3_s, p4_s, p7_s, p8_s, p10_s, p11_s;
  logic signed [15:0] p9_s;
  logic        [15:0] p5_c;

  assign t1_c  = cal[15:0];
  assign t2_s  = $signed({1'b0, cal[31:16]});
  assign t3_s  = $signed(cal[39:32]);
  assign p1m   = 17'($signed(cal[55:40])) - 17'(P_OFFSET);
  assign p2m   = 17'($signed(cal[71:56])) - 17'(P_OFFSET);
  assign p3_s  = $signed(cal[79:72]);
  assign p4_s  = $signed(cal[87:80]);
  assign p5_c  = cal[103:88];
  assign p6_s  = $signed({1'b0, cal[119:104]});
  assign p7_s  = $signed(cal[127:120]);
  assign p8_s  = $signed(cal[135:128]);
  assign p9_s  = $signed(cal[151:136]);
  assign p10_s = $signed(cal[159:152]);
  assign p11_s = $signed(cal[167:160]);

  // stage valids and enables
  logic [NSTG+1:1] en;
  logic [NSTG:1]   v_q, v_d, v_in;

  assign en[NSTG+1] = m_axis_tready;
  for (genvar k = 1; k <= NSTG; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  assign v_in = {v_q[NSTG-1:1], s_axis_tvalid};
  assign v_d  = (en[NSTG:1] & v_in) | (~en[NSTG:1] & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = v_q[NSTG];

  // datapath
  logic        [23:0] up1_q, ut1_q, up2_q, up6, up19;
  logic signed [24:0] d2_q, up2_s, up6_s, up19_s;
  logic signed [41:0] dt2_4, dt2_6;
  logic signed [49:0] dd4, upsq4, upsq19;
  logic signed [57:0] ddt3_6, p11u_6;
  logic signed [82:0] cube8;
  logic signed [60:0] tl7_q, tl7_d;
  logic signed [36:0] t1_8_q, t1_11, t1_14, t1_24;
  logic signed [41:0] cube9_q, cube22;
  logic signed [73:0] t1sq10;
  logic signed [49:0] t2_11_q, t2_14;
  logic signed [86:0] t3p13;
  logic signed [62:0] t3_14_q;
  logic signed [53:0] m6p, m2p;
  logic signed [44:0] m10p;
  logic signed [57:0] m7p, m3p;
  logic signed [70:0] m8p, m4p;
  logic signed [47:0] r6_q;
  logic signed [49:0] r7_q, r3_q;
  logic signed [55:0] r8_q;
  logic signed [48:0] r2_q;
  logic signed [57:0] r4_q;
  logic signed [45:0] q72_17_q, q72_19;
  logic signed [59:0] oa_q, ob_q, sa_q, sb_q;
  logic signed [60:0] off19_q, sens19_q, off22;
  logic signed [85:0] msp;
  logic signed [95:0] mqp;
  logic signed [61:0] rs22_q;
  logic signed [47:0] rq22_q;
  logic signed [62:0] psa23_q;
  logic signed [48:0] psb23_q;
  logic signed [63:0] sum24_q;
  logic signed [71:0] mpcp;
  logic signed [44:0] mtcp;
  logic signed [47:0] pc27_q;
  logic signed [20:0] tc27_q;
  logic signed [14:0] temp_q, temp_d;
  logic        [23:0] press_q, press_d;
  logic               sat_q, sat_d;

  logic signed [RND_W-1:0] rn_cube, rn_t1, rn_t2, rn_t3, rn_6, rn_7, rn_8, rn_2, rn_3, rn_4;
  logic signed [RND_W-1:0] rn_s, rn_q, rn_pc, rn_tc;

  assign up2_s  = $signed({1'b0, up2_q});
  assign up6_s  = $signed({1'b0, up6});
  assign up19_s = $signed({1'b0, up19});

  assign tl7_d = (61'(dt2_6) <<< 18) + 61'(ddt3_6);

  assign rn_cube = bpc_rnd(cube8, 41);
  assign rn_t1   = bpc_rnd(tl7_q, 24);
  assign rn_t2   = bpc_rnd(t1sq10, 24);
  assign rn_t3   = bpc_rnd(t3p13, 24);
  assign rn_6    = bpc_rnd(m6p, 6);
  assign rn_7    = bpc_rnd(m7p, 8);
  assign rn_8    = bpc_rnd(m8p, 15);
  assign rn_2    = bpc_rnd(m2p, 5);
  assign rn_3    = bpc_rnd(m3p, 8);
  assign rn_4    = bpc_rnd(m4p, 13);
  assign rn_s    = bpc_rnd(msp, 24);
  assign rn_q    = bpc_rnd(mqp, 48);
  assign rn_pc   = bpc_rnd(mpcp, 24);
  assign rn_tc   = bpc_rnd(mtcp, 24);

  always_comb begin
    sat_d   = 1'b0;
    temp_d  = 15'(tc27_q);
    press_d = pc27_q[23:0];
    if (tc27_q < 21'(TEMP_MIN)) begin
      temp_d = 15'(TEMP_MIN);
      sat_d  = 1'b1;
    end else if (tc27_q > 21'(TEMP_MAX)) begin
      temp_d = 15'(TEMP_MAX);
      sat_d  = 1'b1;
    end
    if (pc27_q < 48'sd0) begin
      press_d = '0;
      sat_d   = 1'b1;
    end else if (pc27_q > 48'(PRESS_MAX)) begin
      press_d = 24'(PRESS_MAX);
      sat_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      up1_q <= s_axis_tdata[23:0];
      ut1_q <= s_axis_tdata[47:24];
    end
    if (en[2]) begin
      d2_q  <= $signed({1'b0, ut1_q}) - $signed({1'b0, t1_c, 8'd0});
      up2_q <= up1_q;
    end
    if (en[7]) begin
      tl7_q <= tl7_d;
    end
    if (en[8]) begin
      t1_8_q <= rn_t1[36:0];
    end
    if (en[9]) begin
      cube9_q <= rn_cube[41:0];
    end
    if (en[11]) begin
      t2_11_q <= rn_t2[49:0];
    end
    if (en[14]) begin
      t3_14_q <= rn_t3[62:0];
    end
    if (en[17]) begin
      r6_q     <= rn_6[47:0];
      r7_q     <= rn_7[49:0];
      r8_q     <= rn_8[55:0];
      r2_q     <= rn_2[48:0];
      r3_q     <= rn_3[49:0];
      r4_q     <= rn_4[57:0];
      q72_17_q <= (46'(p9_s) <<< 24) + 46'(m10p);
    end
    if (en[18]) begin
      oa_q <= 60'($signed({1'b0, p5_c, 27'd0})) + 60'(r6_q);
      ob_q <= 60'(r7_q) + 60'(r8_q);
      sa_q <= (60'(p1m) <<< 28) + 60'(r2_q);
      sb_q <= 60'(r3_q) + 60'(r4_q);
    end
    if (en[19]) begin
      off19_q  <= 61'(oa_q) + 61'(ob_q);
      sens19_q <= 61'(sa_q) + 61'(sb_q);
    end
    if (en[22]) begin
      rs22_q <= rn_s[61:0];
      rq22_q <= rn_q[47:0];
    end
    if (en[23]) begin
      psa23_q <= 63'(off22) + 63'(rs22_q);
      psb23_q <= 49'(rq22_q) + 49'(cube22);
    end
    if (en[24]) begin
      sum24_q <= 64'(psa23_q) + 64'(psb23_q);
    end
    if (en[27]) begin
      pc27_q <= rn_pc[47:0];
      tc27_q <= rn_tc[20:0];
    end
    if (en[28]) begin
      temp_q  <= temp_d;
      press_q <= press_d;
      sat_q   <= sat_d;
    end
  end

  assign m_axis_tdata = {sat_q, press_q, temp_q};

  // linearized temperature
  bpc_mul #(.AW(25), .BW(17)) u_mul_dt2 (
    .clk_i, .en_i(en[4:3]), .a_i(d2_q), .b_i(t2_s), .p_o(dt2_4));
  bpc_mul #(.AW(25), .BW(25)) u_mul_dd (
    .clk_i, .en_i(en[4:3]), .a_i(d2_q), .b_i(d2_q), .p_o(dd4));
  bpc_mul #(.AW(25), .BW(25)) u_mul_upsq (
    .clk_i, .en_i(en[4:3]), .a_i(up2_s), .b_i(up2_s), .p_o(upsq4));
  bpc_mul #(.AW(50), .BW(8)) u_mul_ddt3 (
    .clk_i, .en_i(en[6:5]), .a_i(dd4), .b_i(t3_s), .p_o(ddt3_6));
  bpc_mul #(.AW(50), .BW(8)) u_mul_p11 (
    .clk_i, .en_i(en[6:5]), .a_i(upsq4), .b_i(p11_s), .p_o(p11u_6));
  bpc_mul #(.AW(58), .BW(25)) u_mul_cube (
    .clk_i, .en_i(en[8:7]), .a_i(p11u_6), .b_i(up6_s), .p_o(cube8));
  bpc_mul #(.AW(37), .BW(37)) u_mul_t2 (
    .clk_i, .en_i(en[10:9]), .a_i(t1_8_q), .b_i(t1_8_q), .p_o(t1sq10));
  bpc_mul #(.AW(50), .BW(37)) u_mul_t3 (
    .clk_i, .en_i(en[13:12]), .a_i(t2_11_q), .b_i(t1_11), .p_o(t3p13));

  // offset and sensitivity terms
  bpc_mul #(.AW(37), .BW(17)) u_mul_p6 (
    .clk_i, .en_i(en[16:15]), .a_i(t1_14), .b_i(p6_s), .p_o(m6p));
  bpc_mul #(.AW(37), .BW(17)) u_mul_p2 (
    .clk_i, .en_i(en[16:15]), .a_i(t1_14), .b_i(p2m), .p_o(m2p));
  bpc_mul #(.AW(37), .BW(8)) u_mul_p10 (
    .clk_i, .en_i(en[16:15]), .a_i(t1_14), .b_i(p10_s), .p_o(m10p));
  bpc_mul #(.AW(50), .BW(8)) u_mul_p7 (
    .clk_i, .en_i(en[16:15]), .a_i(t2_14), .b_i(p7_s), .p_o(m7p));
  bpc_mul #(.AW(50), .BW(8)) u_mul_p3 (
    .clk_i, .en_i(en[16:15]), .a_i(t2_14), .b_i(p3_s), .p_o(m3p));
  bpc_mul #(.AW(63), .BW(8)) u_mul_p8 (
    .clk_i, .en_i(en[16:15]), .a_i(t3_14_q), .b_i(p8_s), .p_o(m8p));
  bpc_mul #(.AW(63), .BW(8)) u_mul_p4 (
    .clk_i, .en_i(en[16:15]), .a_i(t3_14_q), .b_i(p4_s), .p_o(m4p));

  // pressure terms and output scaling
  bpc_mul #(.AW(61), .BW(25)) u_mul_sens (
    .clk_i, .en_i(en[21:20]), .a_i(sens19_q), .b_i(up19_s), .p_o(msp));
  bpc_mul #(.AW(50), .BW(46)) u_mul_sq (
    .clk_i, .en_i(en[21:20]), .a_i(upsq19), .b_i(q72_19), .p_o(mqp));
  bpc_mul #(.AW(64), .BW(8)) u_mul_pc (
    .clk_i, .en_i(en[26:25]), .a_i(sum24_q), .b_i(SCALE_CENTI), .p_o(mpcp));
  bpc_mul #(.AW(37), .BW(8)) u_mul_tc (
    .clk_i, .en_i(en[26:25]), .a_i(t1_24), .b_i(SCALE_CENTI), .p_o(mtcp));

  // alignment
  bpc_delay #(.W(42), .N(2)) u_dly_dt2 (
    .clk_i, .en_i(en[6:5]), .d_i(dt2_4), .q_o(dt2_6));
  bpc_delay #(.W(24), .N(4)) u_dly_up6 (
    .clk_i, .en_i(en[6:3]), .d_i(up2_q), .q_o(up6));
  bpc_delay #(.W(24), .N(13)) u_dly_up19 (
    .clk_i, .en_i(en[19:7]), .d_i(up6), .q_o(up19));
  bpc_delay #(.W(50), .N(15)) u_dly_upsq (
    .clk_i, .en_i(en[19:5]), .d_i(upsq4), .q_o(upsq19));
  bpc_delay #(.W(37), .N(3)) u_dly_t1_11 (
    .clk_i, .en_i(en[11:9]), .d_i(t1_8_q), .q_o(t1_11));
  bpc_delay #(.W(37), .N(3)) u_dly_t1_14 (
    .clk_i, .en_i(en[14:12]), .d_i(t1_11), .q_o(t1_14));
  bpc_delay #(.W(50), .N(3)) u_dly_t2_14 (
    .clk_i, .en_i(en[14:12]), .d_i(t2_11_q), .q_o(t2_14));
  bpc_delay #(.W(37), .N(10)) u_dly_t1_24 (
    .clk_i, .en_i(en[24:15]), .d_i(t1_14), .q_o(t1_24));
  bpc_delay #(.W(46), .N(2)) u_dly_q72 (
    .clk_i, .en_i(en[19:18]), .d_i(q72_17_q), .q_o(q72_19));
  bpc_delay #(.W(61), .N(3)) u_dly_off (
    .clk_i, .en_i(en[22:20]), .d_i(off19_q), .q_o(off22));
  bpc_delay #(.W(42), .N(13)) u_dly_cube (
    .clk_i, .en_i(en[22:10]), .d_i(cube9_q), .q_o(cube22));

endmodule

`default_nettype wire

@@ rtl/bpc_checker.sv @@
`default_nettype none

module bpc_checker
  import bpc_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request dropped or changed while stalled");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[14:0]) >= 15'(TEMP_MIN)
                   && $signed(m_axis_tdata[14:0]) <= 15'(TEMP_MAX))
    else $error("temperature out of range");

  a_press_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[38:15] <= 24'(PRESS_MAX))
    else $error("pressure out of range");

  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && $signed(m_axis_tdata[14:0]) != 15'(TEMP_MIN)
      && $signed(m_axis_tdata[14:0]) != 15'(TEMP_MAX)
      && m_axis_tdata[38:15] != 24'd0 && m_axis_tdata[38:15] != 24'(PRESS_MAX)
      |-> !m_axis_tdata[39])
    else $error("clamp flag set on an unclamped result");

endmodule

bind baro_pressure_temp_compensation_unit bpc_checker u_bpc_checker (.*);

`default_nettype wire

@@ tb/tb_baro_pressure_temp_compensation_unit.sv @@
`default_nettype none

module tb_baro_pressure_temp_compensation_unit;
  import bpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic        sat;
    logic [23:0] pres;
    logic [14:0] temp;
  } comp_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;  // raw_pressure, raw_temperature
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;  // temperature_centideg, pressure_centipascal, saturated

  logic [63:0] calib_low, calib_mid, calib_high;
  comp_result_t pending_results[$];
  int unsigned error_count = 0;
  bit burst_mode = 1'b0;

  baro_pressure_temp_compensation_unit u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #10 clk_i = ~clk_i;

  function automatic longint mul_round(longint a, longint b, int unsigned n);
    logic signed [127:0] prod;
    logic [127:0] mag, r;
    prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    mag = prod[127] ? -prod : prod;
    r = (mag + (128'd1 << (n - 1))) >> n;
    if (r > 128'h7FFF_FFFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF_FFFF;
    return prod[127] ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  function automatic longint cal_byte(int i);
    if (i < 8) return longint'((calib_low >> (8 * i)) & 64'hFF);
    if (i < 16) return longint'((calib_mid >> (8 * (i - 8))) & 64'hFF);
    return longint'((calib_high >> (8 * (i - 16))) & 64'hFF);
  endfunction

  function automatic longint cal_s8(int i);
    longint v;
    v = cal_byte(i);
    return (v >= 128) ? v - 256 : v;
  endfunction

  function automatic longint cal_u16(int i);
    return cal_byte(i) | (cal_byte(i + 1) << 8);
  endfunction

  function automatic longint cal_s16(int i);
    longint v;
    v = cal_u16(i);
    return (v >= 32768) ? v - 65536 : v;
  endfunction

  function automatic comp_result_t compensate(logic [23:0] raw_p, logic [23:0] raw_t);
    longint up, ut, d, tl48, t1v, t2v, t3v, off, sens, up2, q72, sum, tc, pc;
    comp_result_t res;
    res.sat = 1'b0;
    up = longint'(raw_p);
    ut = longint'(raw_t);
    d = ut - cal_u16(0) * 256;
    tl48 = d * cal_u16(2) * 262144 + d * d * cal_s8(4);
    t1v = mul_round(tl48, 1, 24);
    t2v = mul_round(t1v, t1v, 24);
    t3v = mul_round(t2v, t1v, 24);
    off = cal_u16(11) * 134217728 + mul_round(cal_u16(13), t1v, 6)
        + mul_round(cal_s8(15), t2v, 8) + mul_round(cal_s8(16), t3v, 15);
    sens = (cal_s16(5) - P_OFFSET) * 268435456
         + mul_round(cal_s16(7) - P_OFFSET, t1v, 5)
         + mul_round(cal_s8(9), t2v, 8) + mul_round(cal_s8(10), t3v, 13);
    up2 = up * up;
    q72 = cal_s16(17) * 16777216 + cal_s8(19) * t1v;
    sum = off + mul_round(up, sens, 24) + mul_round(up2, q72, 48)
        + mul_round(up2 * cal_s8(20), up, 41);
    tc = mul_round(t1v, 100, 24);
    if (tc < TEMP_MIN) begin tc = TEMP_MIN; res.sat = 1'b1; end
    if (tc > TEMP_MAX) begin tc = TEMP_MAX; res.sat = 1'b1; end
    pc = mul_round(sum, 100, 24);
    if (pc < 0) begin pc = 0; res.sat = 1'b1; end
    if (pc > PRESS_MAX) begin pc = PRESS_MAX; res.sat = 1'b1; end
    res.temp = tc[14:0];
    res.pres = pc[23:0];
    return res;
  endfunction

  function automatic int pick_gap();
    if (burst_mode || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Output side: random stalls, mostly short.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    comp_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.temp !== want.temp) begin
          $error("temperature_centideg exp %0d got %0d",
                 $signed(want.temp), $signed(got.temp));
          error_count++;
        end
        if (got.pres !== want.pres) begin
          $error("pressure_centipascal exp %0d got %0d", want.pres, got.pres);
          error_count++;
        end
        if (got.sat !== want.sat) begin
          $error("saturated exp %0d got %0d", want.sat, got.sat);
          error_count++;
        end
      end
    end
  end

  // Called and returns on a rising edge; leaves tvalid high after acceptance.
  task automatic send_sample(logic [23:0] raw_p, logic [23:0] raw_t);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {raw_t, raw_p};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    pending_results.push_back(compensate(raw_p, raw_t));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (NSTG + 4) @(posedge clk_i);
  endtask

  task automatic write_calib(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CALIB_LOW:  calib_low = value;
      CFG_CALIB_MID:  calib_mid = value;
      CFG_CALIB_HIGH: calib_high = value & 64'hFF_FFFF_FFFF;
      default: ;
    endcase
  endtask

  task automatic load_calib(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi);
    drain();
    write_calib(CFG_CALIB_LOW, lo);
    write_calib(CFG_CALIB_MID, mid);
    write_calib(CFG_CALIB_HIGH, hi);
  endtask

  localparam logic [63:0] TYP_LOW  = 64'h00_EE_00_F9_48_00_6B_80;
  localparam logic [63:0] TYP_MID  = 64'h03_73_80_31_80_00_22_F0;
  localparam logic [63:0] TYP_HIGH = 64'hF4_04_10_00_F9;

  function automatic logic [23:0] near(logic [23:0] center);
    return center + 24'($urandom_range(0, 24'h1FFFFF)) - 24'h0FFFFF;
  endfunction

  task automatic test_reset_calib();
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h5A5A5A, 24'hA5A5A5);
  endtask

  task automatic test_typical_calib();
    load_calib(TYP_LOW, TYP_MID, TYP_HIGH);
    write_calib(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'h6B0000, 24'h7A0000);
    send_sample(24'h680000, 24'h6C0000);
    send_sample(24'h600000, 24'h800000);
    send_sample(24'h400000, 24'h740000);
  endtask

  task automatic test_extreme_calib();
    load_calib('1, '1, '1);
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'h000000, 24'hFFFFFF);
    load_calib(64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080, 64'hFFFF_FF80_8080_8080);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000001, 24'h800000);
    load_calib(64'h7F7F_7F7F_7F7F_7F7F, 64'h7F7F_7F7F_7F7F_7F7F, 64'h7F_7F7F_7F7F);
    send_sample(24'hFFFFFF, 24'h7F7F00);
    send_sample(24'h123456, 24'h7F7F7F);
    load_calib(TYP_LOW, TYP_MID, 64'hAB00_00F4_0410_00F9);
    send_sample(24'h6A0000, 24'h7B0000);
  endtask

  task automatic test_random_phases();
    logic [63:0] lo, mid, hi;
    int phase_items;
    for (int phase = 0; phase < 16; phase++) begin
      burst_mode = (phase % 4 == 3);
      if (phase % 2 == 0) begin
        lo = {$urandom, $urandom};
        mid = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end else begin
        // perturb the typical set so results stay mostly in range
        lo = TYP_LOW ^ {32'($urandom_range(0, 255)) << 8, 32'($urandom_range(0, 15) << 16)};
        mid = TYP_MID ^ 64'($urandom_range(0, 255));
        hi = TYP_HIGH ^ 64'($urandom_range(0, 15));
      end
      load_calib(lo, mid, hi);
      phase_items = 100;
      for (int k = 0; k < phase_items; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_sample(24'($urandom), 24'($urandom));
        else
          send_sample(near(24'h680000), near(24'h760000));
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    calib_low = '0;
    calib_mid = '0;
    calib_high = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_calib();
    test_typical_calib();
    test_extreme_calib();
    test_random_phases();
    drain();
    if (error_count == 0) begin
      $display("baro_pressure_temp_compensation_unit regression: pass");
    end else begin
      $display("baro_pressure_temp_compensation_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("baro_pressure_temp_compensation_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

@@ baro_pressure_temp_compensation_unit.f @@
rtl/bpc_pkg.sv
rtl/bpc_mul.sv
rtl/bpc_delay.sv
rtl/baro_pressure_temp_compensation_unit.sv
rtl/bpc_checker.sv
tb/tb_baro_pressure_temp_compensation_unit.sv
